>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/srr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srr_pkg
// Shared constants, codes and payload types of the selective repeat receiver.
// ---------------------------------------------------------------------------
package srr_pkg;

  // Reorder ring depth (power of two) and fixed header size in bytes
  localparam int RING_DEPTH   = 16;
  localparam int HEADER_BYTES = 12;
  localparam int IDX_W        = $clog2(RING_DEPTH);
  localparam int WALK_W       = $clog2(RING_DEPTH);

  // Last count allowed for the buffered-payload walk
  localparam logic [WALK_W-1:0] WALK_LAST = WALK_W'(RING_DEPTH - 1);

  // Packet types
  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_SYN   = 2'd1;
  localparam logic [1:0] OP_FIN   = 2'd2;
  localparam logic [1:0] OP_OTHER = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_DELIVER = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_RESET   = 2'd2;

  // Connection state
  typedef enum logic [1:0] {
    CONN_LISTEN = 2'd0,
    CONN_EST    = 2'd1,
    CONN_TW     = 2'd2
  } conn_t;

  // One packet header
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] seq_number;
    logic [10:0] packet_len;
    logic [15:0] payload_tag;
  } in_item_t;

  // One result
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] deliver_tag;
    logic [10:0] deliver_len;
    logic [31:0] ack_number;
    logic [4:0]  ack_window;
    logic        last;
  } out_item_t;

  // One reorder ring entry
  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] tag;
    logic [10:0] len;
  } slot_t;

  // Ring access requests from the sequencer
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    slot_t            wr_slot;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             clr_en;
    logic [IDX_W-1:0] clr_idx;
  } ring_req_t;

  // Ring slot of a sequence number
  function automatic logic [IDX_W-1:0] slot_idx(input logic [31:0] s);
    return s[IDX_W-1:0];
  endfunction

endpackage

>>> rtl/core/srr_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module srr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port, data held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/srr_ring.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srr_ring
// Reorder ring: slot RAM plus per-slot valid flags and the match check.
// ---------------------------------------------------------------------------
module srr_ring (
  input  logic                clk,
  input  logic                rst_n,
  input  srr_pkg::ring_req_t  req,
  input  logic [31:0]         chk_seq,
  output srr_pkg::slot_t      rd_slot,
  output logic                hit
);

  logic [srr_pkg::RING_DEPTH-1:0] valid_r;
  logic [srr_pkg::RING_DEPTH-1:0] valid_nxt;
  logic [$bits(srr_pkg::slot_t)-1:0] rd_bits;

  // Slot storage
  srr_ram #(
    .WIDTH ($bits(srr_pkg::slot_t)),
    .DEPTH (srr_pkg::RING_DEPTH)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_idx),
    .wr_data (req.wr_slot),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_idx),
    .rd_data (rd_bits)
  );

  assign rd_slot = srr_pkg::slot_t'(rd_bits);

  // Valid flags: set on store, cleared on delivery
  always_comb begin
    valid_nxt = valid_r;
    if (req.wr_en) begin
      valid_nxt[req.wr_idx] = 1'b1;
    end
    if (req.clr_en) begin
      valid_nxt[req.clr_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Slot holds exactly the wanted sequence number
  assign hit = valid_r[srr_pkg::slot_idx(chk_seq)] && (rd_slot.seq == chk_seq);

endmodule

>>> rtl/core/selective_repeat_receiver.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// selective_repeat_receiver
// Receiver side of a selective repeat sliding-window protocol.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one packet header per transfer (type, sequence, length, handle).
//   out_* : results (deliver, ack, reset); last marks the final result of a
//           packet. A packet with no results (short or refused) emits nothing.
//   cfg_* : receive window write; always ready, write only while idle.
// Sequencing:
//   A header is taken in ST_IDLE and evaluated in ST_EVAL, which also
//   emits its first result. A reset result is followed by an ack from
//   ST_ACK. An in-order payload is followed by each delivered buffered
//   payload and then the ack: the walk reads one ring slot per cycle, while
//   the output is not stalled, from the single read port of the slot RAM.
//   A packet yields at most 1 + (ring depth - 1) + 1 = 17 results.
// Reset:
//   Connection goes to listen, next expected to 1, error count to 0, window
//   to 16, all ring slots invalid. No clearing pass is needed.
// Stall:
//   Results sit in one output register; while one waits on out_ready the block
//   holds its progress. One new header may still be taken while the final
//   result of the previous packet waits; it is evaluated once that drains.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module selective_repeat_receiver (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srr_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srr_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [4:0]          cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_WALK = 4'b0100,
    ST_ACK  = 4'b1000
  } fsm_t;

  fsm_t                          state_r, state_nxt;
  srr_pkg::conn_t                conn_r, conn_nxt;
  srr_pkg::in_item_t             item_r, item_nxt;
  logic [31:0]                   ne_r, ne_nxt;
  logic [15:0]                   err_r, err_nxt;
  logic [4:0]                    win_r;
  logic [srr_pkg::WALK_W-1:0]    walked_r, walked_nxt;
  logic                          out_valid_r, out_valid_nxt;
  srr_pkg::out_item_t            out_data_r;

  logic                          emit;
  srr_pkg::out_item_t            emit_item;
  srr_pkg::ring_req_t            req;
  srr_pkg::slot_t                rd_slot;
  logic                          hit;
  logic                          emit_ok;
  logic                          walk_more;
  logic                          short_pkt;
  logic [4:0]                    eff_win;
  logic [10:0]                   plen;
  logic [31:0]                   seq_gap;
  logic [31:0]                   seq_inc;
  logic [15:0]                   err_sat;

  // Result builders
  function automatic srr_pkg::out_item_t mk_ack(input logic [31:0] n, input logic [4:0] w);
    srr_pkg::out_item_t r;
    r             = '0;
    r.result_kind = srr_pkg::KIND_ACK;
    r.ack_number  = n;
    r.ack_window  = w;
    r.last        = 1'b1;
    return r;
  endfunction

  function automatic srr_pkg::out_item_t mk_reset();
    srr_pkg::out_item_t r;
    r             = '0;
    r.result_kind = srr_pkg::KIND_RESET;
    return r;
  endfunction

  function automatic srr_pkg::out_item_t mk_deliver(input logic [15:0] t, input logic [10:0] l);
    srr_pkg::out_item_t r;
    r             = '0;
    r.result_kind = srr_pkg::KIND_DELIVER;
    r.deliver_tag = t;
    r.deliver_len = l;
    return r;
  endfunction

  // Reorder ring
  srr_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .chk_seq (ne_r),
    .rd_slot (rd_slot),
    .hit     (hit)
  );

  // Datapath terms
  assign eff_win   = (32'(win_r) > 32'(srr_pkg::RING_DEPTH)) ?
                     5'(srr_pkg::RING_DEPTH) : win_r;
  assign short_pkt = item_r.packet_len < 11'(srr_pkg::HEADER_BYTES);
  assign plen      = item_r.packet_len - 11'(srr_pkg::HEADER_BYTES);
  assign seq_gap   = item_r.seq_number - ne_r;
  assign seq_inc   = item_r.seq_number + 32'd1;
  assign err_sat   = (err_r == 16'hFFFF) ? err_r : err_r + 16'd1;
  assign emit_ok   = !out_valid_r || out_ready;
  assign walk_more = hit && (walked_r != srr_pkg::WALK_LAST);

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    conn_nxt   = conn_r;
    item_nxt   = item_r;
    ne_nxt     = ne_r;
    err_nxt    = err_r;
    walked_nxt = walked_r;
    emit       = 1'b0;
    emit_item  = '0;
    req        = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (emit_ok) begin
          state_nxt = ST_IDLE;
          if (short_pkt) begin
            err_nxt = err_sat;
          end else if (conn_r == srr_pkg::CONN_LISTEN) begin
            ne_nxt   = seq_inc;
            conn_nxt = srr_pkg::CONN_EST;
            emit     = 1'b1;
            if (item_r.op != srr_pkg::OP_SYN) begin
              emit_item = mk_reset();
              state_nxt = ST_ACK;
            end else begin
              emit_item = mk_ack(seq_inc, eff_win);
            end
          end else if (conn_r != srr_pkg::CONN_EST) begin
            // time-wait: only a FIN is answered
            if (item_r.op != srr_pkg::OP_FIN) begin
              err_nxt = err_sat;
            end else begin
              emit = 1'b1;
              if (item_r.seq_number != ne_r - 32'd1) begin
                emit_item = mk_reset();
                state_nxt = ST_ACK;
              end else begin
                emit_item = mk_ack(ne_r, eff_win);
              end
            end
          end else if (item_r.op == srr_pkg::OP_FIN) begin
            ne_nxt   = seq_inc;
            conn_nxt = srr_pkg::CONN_TW;
            emit     = 1'b1;
            if (item_r.seq_number != ne_r) begin
              emit_item = mk_reset();
              state_nxt = ST_ACK;
            end else begin
              emit_item = mk_ack(seq_inc, eff_win);
            end
          end else if (seq_gap >= 32'(eff_win)) begin
            emit      = 1'b1;
            emit_item = mk_ack(ne_r, eff_win);
          end else if (seq_gap == 32'd0) begin
            // in order: deliver, then look up the following slot
            emit        = 1'b1;
            emit_item   = mk_deliver(item_r.payload_tag, plen);
            ne_nxt      = seq_inc;
            walked_nxt  = '0;
            req.rd_en   = 1'b1;
            req.rd_idx  = srr_pkg::slot_idx(seq_inc);
            state_nxt   = ST_WALK;
          end else begin
            // out of order inside the window: store
            req.wr_en        = 1'b1;
            req.wr_idx       = srr_pkg::slot_idx(item_r.seq_number);
            req.wr_slot.seq  = item_r.seq_number;
            req.wr_slot.tag  = item_r.payload_tag;
            req.wr_slot.len  = plen;
            emit             = 1'b1;
            emit_item        = mk_ack(ne_r, eff_win);
          end
        end
      end
      ST_WALK: begin
        if (emit_ok) begin
          emit = 1'b1;
          if (walk_more) begin
            emit_item   = mk_deliver(rd_slot.tag, rd_slot.len);
            req.clr_en  = 1'b1;
            req.clr_idx = srr_pkg::slot_idx(ne_r);
            req.rd_en   = 1'b1;
            req.rd_idx  = srr_pkg::slot_idx(ne_r + 32'd1);
            ne_nxt      = ne_r + 32'd1;
            walked_nxt  = walked_r + 1'b1;
          end else begin
            emit_item = mk_ack(ne_r, eff_win);
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ACK: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_item = mk_ack(ne_r, eff_win);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and connection state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      conn_r      <= srr_pkg::CONN_LISTEN;
      ne_r        <= 32'd1;
      err_r       <= '0;
      win_r       <= 5'd16;
      walked_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      conn_r      <= conn_nxt;
      ne_r        <= ne_nxt;
      err_r       <= err_nxt;
      walked_r    <= walked_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        win_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    if (emit) begin
      out_data_r <= emit_item;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `ASSERT_IMPLIES(a_accept_after_last, in_valid && in_ready,
    !out_valid_r || out_data_r.last, "header taken before previous packet finished")
  `ASSERT_NEXT(a_walk_advances, (state_r == ST_WALK) && emit && walk_more,
    ne_r == $past(ne_r) + 32'd1, "walk delivery did not advance next expected")
  `ASSERT_IMPLIES(a_walk_bound, state_r == ST_WALK,
    32'(walked_r) <= 32'(srr_pkg::RING_DEPTH - 1), "walk ran past ring depth")
  `ASSERT_IMPLIES(a_err_quiet, err_r != $past(err_r), !$past(emit),
    "error counted on a packet that produced results")

endmodule
